@@ sv/vc3_pkg.sv @@
// Package with shared constants, codes and a helper function for the volume convolution.
package vc3_pkg;

    localparam int COEFF_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int RESULT_W   = 32;
    localparam int INDEX_W    = 7;
    localparam int COEF_COUNT = 125;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int RADIUS_W   = 2;
    localparam int SIZE_W     = 7;
    localparam int DEPTH_W    = 13;
    localparam int PD_W       = 13;
    localparam int DEPTH_MAX  = 4096;
    localparam int ROUND_BIAS = 8192;
    localparam int FRAC_SHIFT = 14;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DEPTH  = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_VOXEL = 1'b1;

    // Coefficient index for the tap that lies j planes, i rows and m columns back.
    function automatic int coef_index(int r, int j, int i, int m);
        int k;
        k = 2 * r + 1;
        return ((2 * r - j) * k + (2 * r - i)) * k + (2 * r - m);
    endfunction

endpackage

@@ sv/vc3_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface vc3_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [6:0]         coeff_index;
    logic signed [15:0] sample_value;

    modport source (output valid, output opcode, output coeff_index, output sample_value,
                    input ready);
    modport sink (input valid, input opcode, input coeff_index, input sample_value,
                  output ready);
endinterface

interface vc3_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               saturated;
    logic               last;

    modport source (output valid, output result_value, output saturated, output last,
                    input ready);
    modport sink (input valid, input result_value, input saturated, input last,
                  output ready);
endinterface

@@ sv/vc3_ram.sv @@
// Generic single-port RAM with registered read that returns the old data on a write.
module vc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem_reg[addr] <= wdata;
            rdata_reg     <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/vc3_delay.sv @@
// Programmable-length delay line for samples, built on a ring in RAM.
module vc3_delay #(
    parameter int DEPTH = 64,
    parameter int LW    = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                restart,
    input  logic [LW-1:0]       len,
    input  logic signed [15:0]  din,
    output logic signed [15:0]  dout
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [15:0]   rdata;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (restart)
        begin
            ptr_next = '0;
        end
        else if (en)
        begin
            if (32'(ptr_reg) + 32'd1 >= 32'(len))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    vc3_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (en),
        .addr  (ptr_reg),
        .wdata (din),
        .rdata (rdata)
    );

    assign dout = $signed(rdata);
endmodule

@@ sv/vc3_cell.sv @@
// Window cell: holds one sample, passes it to its neighbor and multiplies it by its coefficient.
module vc3_cell (
    input  logic               clk,
    input  logic               en,
    input  logic               adv,
    input  logic signed [15:0] sample_in,
    input  logic signed [15:0] coef,
    output logic signed [15:0] sample,
    output logic signed [31:0] product
);
    logic signed [15:0] sample_reg;
    logic signed [31:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= sample_in;
        end
        if (adv)
        begin
            // A cell outside the active window may hold a sample from an unfilled buffer.
            if (coef == '0)
            begin
                product_reg <= '0;
            end
            else
            begin
                product_reg <= sample_reg * coef;
            end
        end
    end

    assign sample  = sample_reg;
    assign product = product_reg;
endmodule

@@ sv/volume_convolution_3d.sv @@
// Top level of the zero-padded 3D convolution over a streamed voxel volume.
// A result leaves through the cell sample and product registers, three adder-tree registers and the output register.
// Throughput: one item per cycle; input ready drops only while a result waits downstream.
// The rate is set by the window cells, each with one multiplier, and a three-level adder tree.
// Reset clears the coefficient store, stream position and pipeline valid bits; registers take defaults.
// Line and plane buffers in RAM are not cleared; windows read only voxels of the current volume.
module volume_convolution_3d #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_enable,
    input  logic [vc3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vc3_pkg::CFG_DATA_W-1:0]     cfg_data,
    vc3_in_if.sink                             in_items,
    vc3_out_if.source                          out_items
);
    import vc3_pkg::*;

    localparam int N           = 2 * MAX_RADIUS + 1;
    localparam int PW_MAX      = MAX_WIDTH + 2 * MAX_RADIUS;
    localparam int PH_MAX      = MAX_HEIGHT + 2 * MAX_RADIUS;
    localparam int PW_W        = $clog2(PW_MAX + 1);
    localparam int PH_W        = $clog2(PH_MAX + 1);
    localparam int PP_W        = PW_W + PH_W;
    localparam int ROW_DEPTH   = PW_MAX - 2;
    localparam int PLANE_DEPTH = PW_MAX * PH_MAX - 2;
    localparam int ROW_LW      = $clog2(ROW_DEPTH + 1);
    localparam int PLANE_LW    = $clog2(PLANE_DEPTH + 1);
    localparam int STAGES      = 5;

    logic [RADIUS_W-1:0] radius_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [DEPTH_W-1:0]  depth_reg;

    logic [RADIUS_W-1:0] r_eff;
    logic [31:0]         w32;
    logic [31:0]         h32;
    logic [31:0]         d32;
    logic [PW_W-1:0]     pw;
    logic [PH_W-1:0]     ph;
    logic [PD_W-1:0]     pd;
    logic [PP_W-1:0]     pp_reg;
    logic [ROW_LW-1:0]   row_len;
    logic [PLANE_LW-1:0] plane_len;
    logic                r1;

    logic [PW_W-1:0] col_reg;
    logic [PH_W-1:0] row_reg;
    logic [PD_W-1:0] plane_reg;
    logic            window_done;
    logic            is_last;

    logic adv;
    logic accept;
    logic vox_acc;
    logic load_acc;

    logic                      ld_pend_reg;
    logic [INDEX_W-1:0]        ld_idx_reg;
    logic signed [COEFF_W-1:0] ld_val_reg;
    logic signed [COEFF_W-1:0] coef_reg [COEF_COUNT];

    logic signed [SAMPLE_W-1:0] samp     [N][N][N];
    logic signed [PROD_W-1:0]   prod     [N][N][N];
    logic signed [SAMPLE_W-1:0] row_src  [N][N];

    logic signed [ACC_W-1:0] s1_reg  [N][N];
    logic signed [ACC_W-1:0] s1_next [N][N];
    logic signed [ACC_W-1:0] s2_reg  [N];
    logic signed [ACC_W-1:0] s2_next [N];
    logic signed [ACC_W-1:0] s3_reg;
    logic signed [ACC_W-1:0] s3_next;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] lst_reg;

    logic signed [ACC_W-1:0]    rounded;
    logic [ACC_W-32:0]          top_bits;
    logic                       sat_next;
    logic signed [RESULT_W-1:0] res_next;
    logic                       out_valid_reg;
    logic signed [RESULT_W-1:0] res_reg;
    logic                       sat_reg;
    logic                       last_reg;

    // Effective geometry after clamping the registers to their legal ranges.
    always_comb
    begin
        if (radius_reg == '0)
        begin
            r_eff = RADIUS_W'(1);
        end
        else if (32'(radius_reg) > 32'(MAX_RADIUS))
        begin
            r_eff = RADIUS_W'(MAX_RADIUS);
        end
        else
        begin
            r_eff = radius_reg;
        end
        if (width_reg == '0)
        begin
            w32 = 32'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
        else
        begin
            w32 = 32'(width_reg);
        end
        if (height_reg == '0)
        begin
            h32 = 32'd1;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h32 = 32'(MAX_HEIGHT);
        end
        else
        begin
            h32 = 32'(height_reg);
        end
        if (depth_reg == '0)
        begin
            d32 = 32'd1;
        end
        else if (32'(depth_reg) > 32'(DEPTH_MAX))
        begin
            d32 = 32'(DEPTH_MAX);
        end
        else
        begin
            d32 = 32'(depth_reg);
        end
        pw = PW_W'(w32 + 32'({r_eff, 1'b0}));
        ph = PH_W'(h32 + 32'({r_eff, 1'b0}));
        pd = PD_W'(d32 + 32'({r_eff, 1'b0}));
    end

    assign r1        = (r_eff == RADIUS_W'(1));
    assign row_len   = ROW_LW'(pw - PW_W'(2));
    assign plane_len = PLANE_LW'(pp_reg - PP_W'(2));

    assign window_done = (32'(col_reg) >= 32'({r_eff, 1'b0}))
                      && (32'(row_reg) >= 32'({r_eff, 1'b0}))
                      && (32'(plane_reg) >= 32'({r_eff, 1'b0}));
    assign is_last = (col_reg == pw - PW_W'(1)) && (row_reg == ph - PH_W'(1))
                  && (plane_reg == pd - PD_W'(1));

    assign adv      = !out_valid_reg || out_items.ready;
    assign accept   = in_items.valid && adv;
    assign vox_acc  = accept && (in_items.opcode == OP_VOXEL);
    assign load_acc = accept && (in_items.opcode == OP_LOAD);

    assign in_items.ready = adv;

    always_ff @(posedge clk)
    begin
        pp_reg <= PP_W'(pw) * PP_W'(ph);
    end

    // Configuration registers and padded stream position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            width_reg  <= SIZE_W'(64);
            height_reg <= SIZE_W'(64);
            depth_reg  <= DEPTH_W'(64);
            col_reg    <= '0;
            row_reg    <= '0;
            plane_reg  <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_KERNEL_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_VOLUME_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_VOLUME_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_VOLUME_DEPTH:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                default:           radius_reg <= radius_reg;
            endcase
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
        end
        else if (vox_acc)
        begin
            if (col_reg + PW_W'(1) >= pw)
            begin
                col_reg <= '0;
                if (row_reg + PH_W'(1) >= ph)
                begin
                    row_reg <= '0;
                    if (plane_reg + PD_W'(1) >= pd)
                    begin
                        plane_reg <= '0;
                    end
                    else
                    begin
                        plane_reg <= plane_reg + PD_W'(1);
                    end
                end
                else
                begin
                    row_reg <= row_reg + PH_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + PW_W'(1);
            end
        end
    end

    // Coefficient writes wait in a pending register so that a window ahead of them uses the old set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_pend_reg <= 1'b0;
            for (int e = 0; e < COEF_COUNT; e++)
            begin
                coef_reg[e] <= '0;
            end
        end
        else if (adv)
        begin
            ld_pend_reg <= load_acc;
            if (ld_pend_reg && (32'(ld_idx_reg) < 32'(COEF_COUNT)))
            begin
                coef_reg[ld_idx_reg] <= ld_val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_idx_reg <= in_items.coeff_index;
            ld_val_reg <= in_items.sample_value;
        end
    end

    // The input and the row and plane buffers feed the first cell of each window row.
    assign row_src[0][0] = in_items.sample_value;

    for (genvar j = 0; j < N; j++)
    begin : g_plane
        if (j > 0)
        begin : g_pbuf
            vc3_delay #(
                .DEPTH (PLANE_DEPTH),
                .LW    (PLANE_LW)
            ) u_plane (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (vox_acc),
                .restart (cfg_write_enable),
                .len     (plane_len),
                .din     (samp[j-1][0][0]),
                .dout    (row_src[j][0])
            );
        end
        for (genvar i = 1; i < N; i++)
        begin : g_row
            vc3_delay #(
                .DEPTH (ROW_DEPTH),
                .LW    (ROW_LW)
            ) u_row (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (vox_acc),
                .restart (cfg_write_enable),
                .len     (row_len),
                .din     (samp[j][i-1][0]),
                .dout    (row_src[j][i])
            );
        end
        for (genvar i = 0; i < N; i++)
        begin : g_line
            for (genvar m = 0; m < N; m++)
            begin : g_col
                localparam bit USE1 = (j <= 2) && (i <= 2) && (m <= 2);
                localparam int IDX2 = coef_index(MAX_RADIUS, j, i, m);
                logic signed [SAMPLE_W-1:0] cell_in;
                logic signed [COEFF_W-1:0]  cell_coef;

                if (m == 0)
                begin : g_head
                    assign cell_in = row_src[j][i];
                end
                else
                begin : g_tail
                    assign cell_in = samp[j][i][m-1];
                end

                if (USE1)
                begin : g_c1
                    localparam int IDX1 = coef_index(1, j, i, m);
                    assign cell_coef = r1 ? coef_reg[IDX1] : coef_reg[IDX2];
                end
                else
                begin : g_c2
                    assign cell_coef = r1 ? '0 : coef_reg[IDX2];
                end

                vc3_cell u_cell (
                    .clk       (clk),
                    .en        (vox_acc),
                    .adv       (adv),
                    .sample_in (cell_in),
                    .coef      (cell_coef),
                    .sample    (samp[j][i][m]),
                    .product   (prod[j][i][m])
                );
            end
        end
    end

    // Adder tree: along each window row, then over rows, then over planes.
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            for (int i = 0; i < N; i++)
            begin
                s1_next[j][i] = '0;
                for (int m = 0; m < N; m++)
                begin
                    s1_next[j][i] = s1_next[j][i] + ACC_W'(prod[j][i][m]);
                end
            end
        end
        for (int j = 0; j < N; j++)
        begin
            s2_next[j] = '0;
            for (int i = 0; i < N; i++)
            begin
                s2_next[j] = s2_next[j] + s1_reg[j][i];
            end
        end
        s3_next = '0;
        for (int j = 0; j < N; j++)
        begin
            s3_next = s3_next + s2_reg[j];
        end
    end

    // Round half up from Q25.14 to an integer and clamp to the signed 32-bit result range.
    always_comb
    begin
        rounded  = (s3_reg + ACC_W'(ROUND_BIAS)) >>> FRAC_SHIFT;
        top_bits = rounded[ACC_W-1:31];
        sat_next = !((&top_bits) || !(|top_bits));
        if (sat_next)
        begin
            res_next = rounded[ACC_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                        : {1'b0, {(RESULT_W-1){1'b1}}};
        end
        else
        begin
            res_next = rounded[RESULT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            s3_reg   <= s3_next;
            lst_reg  <= {lst_reg[STAGES-2:0], is_last};
            res_reg  <= res_next;
            sat_reg  <= sat_next;
            last_reg <= lst_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], vox_acc && window_done};
            out_valid_reg <= vld_reg[STAGES-1];
        end
    end

    assign out_items.valid        = out_valid_reg;
    assign out_items.result_value = res_reg;
    assign out_items.saturated    = sat_reg;
    assign out_items.last         = last_reg;
endmodule
